### design/let_pkg.sv
// ----------------------------------------------------------------------------
// let_pkg
// shared types and constants of the lease expiry tracker
// ----------------------------------------------------------------------------
package let_pkg;

  localparam int TIME_W = 63;
  localparam int SLOT_W = 8;
  localparam logic [TIME_W-1:0] T_NEVER = {TIME_W{1'b1}};

  typedef enum logic [2:0] {
    CMD_CREATE     = 3'd0,
    CMD_REGISTER   = 3'd1,
    CMD_UNREGISTER = 3'd2,
    CMD_RENEW      = 3'd3,
    CMD_SET_EXPIRY = 3'd4,
    CMD_CHECK      = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_DONE    = 2'd0,
    KIND_EXPIRED = 2'd1,
    KIND_DELAY   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CREATE,
    OP_REGISTER,
    OP_UNREGISTER,
    OP_RENEW,
    OP_SET,
    OP_VISIT
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [SLOT_W-1:0] idx;
    logic [TIME_W-1:0] tv;
    logic [TIME_W-1:0] dur;
  } cell_req_t;

  typedef struct packed {
    logic              found;
    logic [TIME_W-1:0] chk;
    logic [TIME_W-1:0] tend;
    logic [SLOT_W-1:0] idx;
  } cand_t;

endpackage

### design/let_cell.sv
// ----------------------------------------------------------------------------
// let_cell
// one lease slot: applies addressed requests and passes the earliest
// scheduled candidate on to its neighbor
// ----------------------------------------------------------------------------
module let_cell #(
  parameter logic [7:0] IDX = 8'd0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  let_pkg::cell_req_t req,
  input  let_pkg::cand_t     cand_in,
  output let_pkg::cand_t     cand_out
);
  import let_pkg::*;

  logic [TIME_W-1:0] dur_r, dur_nxt;
  logic [TIME_W-1:0] end_r, end_nxt;
  logic [TIME_W-1:0] chk_r, chk_nxt;
  logic              sch_r, sch_nxt;
  cand_t             cand_r, cand_nxt;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] tnew;
  logic              hit;

  assign hit  = (req.idx == IDX);
  assign sum  = {1'b0, req.tv} + {1'b0, dur_r};
  assign tnew = sum[TIME_W] ? T_NEVER : sum[TIME_W-1:0];

  always_comb begin
    dur_nxt = dur_r;
    end_nxt = end_r;
    chk_nxt = chk_r;
    sch_nxt = sch_r;
    if (hit) begin
      case (req.op)
        OP_CREATE: begin
          dur_nxt = req.dur;
          end_nxt = req.tv;
          sch_nxt = 1'b0;
        end
        OP_REGISTER: begin
          chk_nxt = end_r;
          sch_nxt = (end_r != T_NEVER);
        end
        OP_UNREGISTER: sch_nxt = 1'b0;
        OP_RENEW: begin
          if (tnew > end_r && req.tv < end_r) end_nxt = tnew;
        end
        OP_SET: begin
          end_nxt = req.tv;
          if (sch_r) begin
            if (req.tv < chk_r) chk_nxt = req.tv;
          end else if (req.tv != T_NEVER) begin
            chk_nxt = req.tv;
            sch_nxt = 1'b1;
          end
        end
        OP_VISIT: begin
          chk_nxt = end_r;
          sch_nxt = (req.tv < end_r) && (end_r != T_NEVER);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    cand_nxt = cand_in;
    if (sch_r && (!cand_in.found || chk_r < cand_in.chk)) begin
      cand_nxt.found = 1'b1;
      cand_nxt.chk   = chk_r;
      cand_nxt.tend  = end_r;
      cand_nxt.idx   = IDX;
    end
  end

  always_ff @(posedge clk) begin
    dur_r <= dur_nxt;
    end_r <= end_nxt;
    chk_r <= chk_nxt;
    if (!rst_n) begin
      sch_r  <= 1'b0;
      cand_r <= '0;
    end else begin
      sch_r  <= sch_nxt;
      cand_r <= cand_nxt;
    end
  end

  assign cand_out = cand_r;

endmodule

### design/lease_expiry_tracker_core.sv
// ----------------------------------------------------------------------------
// lease_expiry_tracker_core
// lease table with timeout checking, one cell per lease slot
// ----------------------------------------------------------------------------
//  channel  | ports                                    | handshake
//  request  | in_cmd in_lease_index in_time_value ...  | start & !busy
//  result   | out_kind out_expired_index ...           | out_strobe, 1 cycle
//
//  a non-check request gives its result in the cycle after it is taken
//  a check scans the candidate chain once per due lease visited plus
//  once more for the final scan; each scan lets the whole chain settle
//  reset clears all scheduled flags; busy is low right after reset
//  results cannot be held off by the receiver
// ----------------------------------------------------------------------------
module lease_expiry_tracker_core #(
  parameter int LEASE_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_cmd,
  input  logic [3:0]  in_lease_index,
  input  logic [62:0] in_time_value,
  input  logic [62:0] in_duration,
  output logic        out_strobe,
  output logic [1:0]  out_kind,
  output logic [3:0]  out_expired_index,
  output logic [62:0] out_next_delay,
  output logic        out_last
);
  import let_pkg::*;

  localparam int CW = $clog2(LEASE_SLOTS + 1);

  state_t            state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  cell_req_t         req;
  cand_t             chain [LEASE_SLOTS];
  cand_t             best;
  logic              accept, scan_done, due, expired;
  logic              strobe_nxt, last_nxt;
  kind_t             kind_nxt;
  logic [3:0]        exp_idx_nxt;
  logic [TIME_W-1:0] delay_nxt;

  for (genvar i = 0; i < LEASE_SLOTS; i++) begin : g_cell
    let_cell #(.IDX(8'(i))) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .req     (req),
      .cand_in ((i == 0) ? cand_t'('0) : chain[(i == 0) ? 0 : i - 1]),
      .cand_out(chain[i])
    );
  end

  assign best      = chain[LEASE_SLOTS-1];
  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign scan_done = (state_r == ST_SCAN) && (cnt_r == CW'(LEASE_SLOTS));
  assign due       = best.found && (best.chk <= now_r);
  assign expired   = !(now_r < best.tend);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept && in_cmd == CMD_CHECK) state_nxt = ST_SCAN;
      ST_SCAN: if (scan_done && !due) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    req         = '0;
    req.op      = OP_NONE;
    cnt_nxt     = cnt_r;
    now_nxt     = now_r;
    strobe_nxt  = 1'b0;
    kind_nxt    = KIND_DONE;
    exp_idx_nxt = '0;
    delay_nxt   = '0;
    last_nxt    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          req.idx = {4'd0, in_lease_index};
          req.tv  = in_time_value;
          req.dur = in_duration;
          cnt_nxt = '0;
          now_nxt = in_time_value;
          if (in_cmd != CMD_CHECK) begin
            strobe_nxt = 1'b1;
            last_nxt   = 1'b1;
            if ({5'd0, in_lease_index} < 9'(LEASE_SLOTS)) begin
              case (in_cmd)
                CMD_CREATE:     req.op = OP_CREATE;
                CMD_REGISTER:   req.op = OP_REGISTER;
                CMD_UNREGISTER: req.op = OP_UNREGISTER;
                CMD_RENEW:      req.op = OP_RENEW;
                CMD_SET_EXPIRY: req.op = OP_SET;
                default:        req.op = OP_NONE;
              endcase
            end
          end
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + CW'(1);
        if (scan_done) begin
          cnt_nxt = '0;
          if (due) begin
            req.op      = OP_VISIT;
            req.idx     = best.idx;
            req.tv      = now_r;
            strobe_nxt  = expired;
            kind_nxt    = KIND_EXPIRED;
            exp_idx_nxt = best.idx[3:0];
          end else begin
            strobe_nxt = 1'b1;
            kind_nxt   = KIND_DELAY;
            delay_nxt  = best.found ? (best.chk - now_r) : T_NEVER;
            last_nxt   = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    cnt_r             <= cnt_nxt;
    now_r             <= now_nxt;
    out_kind          <= kind_nxt;
    out_expired_index <= exp_idx_nxt;
    out_next_delay    <= delay_nxt;
    out_last          <= last_nxt;
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      out_strobe <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      out_strobe <= strobe_nxt;
    end
  end

endmodule

### design/let_checker.sv
// ----------------------------------------------------------------------------
// let_checker
// port-level properties of the lease expiry tracker
// ----------------------------------------------------------------------------
module let_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [2:0]  in_cmd,
  input logic        out_strobe,
  input logic [1:0]  out_kind,
  input logic        out_last
);
  import let_pkg::*;

  a_cmd_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_cmd != CMD_CHECK |=> out_strobe && out_kind == KIND_DONE && out_last)
    else $error("command request without done result");

  a_expired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_kind == KIND_EXPIRED |-> !out_last && busy)
    else $error("expired report ended the check");

  a_delay_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_kind == KIND_DELAY |-> out_last && !busy)
    else $error("delay result not final");

  a_kind_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_kind == KIND_DONE || out_kind == KIND_EXPIRED ||
                   out_kind == KIND_DELAY)
    else $error("bad result kind");

endmodule

bind lease_expiry_tracker_core let_checker u_let_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_cmd    (in_cmd),
  .out_strobe(out_strobe),
  .out_kind  (out_kind),
  .out_last  (out_last)
);

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// checks lease_expiry_tracker_core against a cycle-free lease table model:
// directed requests cover the field extremes and every command, then random
// requests with random gaps are checked result by result in a scoreboard
// ----------------------------------------------------------------------------
import let_pkg::*;

typedef struct {
  kind_t       kind;
  logic [3:0]  idx;
  logic [62:0] delay;
  logic        last;
} lease_result_t;

class lease_scoreboard;
  localparam int N_SLOTS = 16;
  logic [62:0] dur_tab[N_SLOTS];
  logic [62:0] end_tab[N_SLOTS];
  logic [62:0] chk_tab[N_SLOTS];
  bit          sched[N_SLOTS];
  lease_result_t expected_results[$];
  int          errors;
  int          checked;
  int          expirations;

  function new();
    for (int i = 0; i < N_SLOTS; i++) begin
      dur_tab[i] = '0;
      end_tab[i] = '0;
      chk_tab[i] = '0;
      sched[i] = 0;
    end
    errors = 0;
    checked = 0;
    expirations = 0;
  endfunction

  function void push_result(kind_t k, logic [3:0] idx, logic [62:0] d, logic l);
    lease_result_t r;
    r.kind = k;
    r.idx = idx;
    r.delay = d;
    r.last = l;
    expected_results.push_back(r);
  endfunction

  function int earliest_slot();
    int best;
    best = -1;
    for (int i = 0; i < N_SLOTS; i++)
      if (sched[i] && (best < 0 || chk_tab[i] < chk_tab[best])) best = i;
    return best;
  endfunction

  function void note_request(logic [2:0] cmd, logic [3:0] idx, logic [62:0] tv,
                             logic [62:0] dur);
    int m;
    logic [63:0] sum;
    if (cmd == CMD_CHECK) begin
      m = earliest_slot();
      while (m >= 0 && chk_tab[m] <= tv) begin
        sched[m] = 0;
        if (tv < end_tab[m]) begin
          if (end_tab[m] != T_NEVER) begin
            chk_tab[m] = end_tab[m];
            sched[m] = 1;
          end
        end else begin
          push_result(KIND_EXPIRED, m[3:0], '0, 1'b0);
          expirations++;
        end
        m = earliest_slot();
      end
      push_result(KIND_DELAY, '0, (m < 0) ? T_NEVER : chk_tab[m] - tv, 1'b1);
      return;
    end
    case (cmd)
      CMD_CREATE: begin
        dur_tab[idx] = dur;
        end_tab[idx] = tv;
        sched[idx] = 0;
      end
      CMD_REGISTER: begin
        if (end_tab[idx] != T_NEVER) begin
          chk_tab[idx] = end_tab[idx];
          sched[idx] = 1;
        end else begin
          sched[idx] = 0;
        end
      end
      CMD_UNREGISTER: sched[idx] = 0;
      CMD_RENEW: begin
        sum = {1'b0, tv} + {1'b0, dur_tab[idx]};
        if (sum > {1'b0, T_NEVER}) sum = {1'b0, T_NEVER};
        if (sum[62:0] > end_tab[idx] && tv < end_tab[idx]) end_tab[idx] = sum[62:0];
      end
      CMD_SET_EXPIRY: begin
        end_tab[idx] = tv;
        if (sched[idx]) begin
          if (tv < chk_tab[idx]) chk_tab[idx] = tv;
        end else if (tv < T_NEVER) begin
          chk_tab[idx] = tv;
          sched[idx] = 1;
        end
      end
      default: ;
    endcase
    push_result(KIND_DONE, '0, '0, 1'b1);
  endfunction

  task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("error at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  task check_result(logic [1:0] kind, logic [3:0] idx, logic [62:0] d, logic l);
    lease_result_t e;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result kind", 64'(kind), 64'd0);
      return;
    end
    e = expected_results.pop_front();
    checked++;
    if (kind !== e.kind) report_mismatch("kind", 64'(kind), 64'(e.kind));
    if (idx !== e.idx) report_mismatch("expired_index", 64'(idx), 64'(e.idx));
    if (d !== e.delay) report_mismatch("next_delay", 64'(d), 64'(e.delay));
    if (l !== e.last) report_mismatch("last", 64'(l), 64'(e.last));
  endtask
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CMD_BAD_LO = 3'd6;
  localparam logic [2:0] CMD_BAD_HI = 3'd7;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_REQUESTS = 360;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [2:0]  in_cmd = '0;
  logic [3:0]  in_lease_index = '0;
  logic [62:0] in_time_value = '0;
  logic [62:0] in_duration = '0;
  logic        out_strobe;
  logic [1:0]  out_kind;
  logic [3:0]  out_expired_index;
  logic [62:0] out_next_delay;
  logic        out_last;

  lease_scoreboard sb = new();
  int cycles = 0;
  int requests = 0;
  logic [62:0] now_t = '0;

  lease_expiry_tracker_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_lease_index(in_lease_index),
    .in_time_value(in_time_value), .in_duration(in_duration),
    .out_strobe(out_strobe), .out_kind(out_kind),
    .out_expired_index(out_expired_index), .out_next_delay(out_next_delay),
    .out_last(out_last)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("lease_expiry_tracker_core: mismatch");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_strobe)
      sb.check_result(out_kind, out_expired_index, out_next_delay, out_last);

  function automatic logic [62:0] rand_wide();
    return 63'({$urandom, $urandom});
  endfunction

  function automatic logic [62:0] pick_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return now_t + 63'($urandom_range(0, 200));
    if (r < 80) return now_t - 63'($urandom_range(0, 100));
    if (r < 88) return T_NEVER;
    return rand_wide();
  endfunction

  function automatic logic [62:0] pick_duration();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 63'($urandom_range(0, 300));
    if (r < 85) return rand_wide();
    return T_NEVER;
  endfunction

  task automatic send_request(logic [2:0] cmd, logic [3:0] idx, logic [62:0] tv,
                              logic [62:0] dur, int gap);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    in_cmd <= cmd;
    in_lease_index <= idx;
    in_time_value <= tv;
    in_duration <= dur;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_request(cmd, idx, tv, dur);
    requests++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    int r;
    logic [2:0] cmd;
    logic [62:0] tv;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // create every slot first so no later read sees an unwritten entry
    for (int i = 0; i < 16; i++) begin
      case (i)
        0: tv = '0;
        1: tv = T_NEVER;
        3: tv = 63'h5555_5555_5555_5555;
        default: tv = 63'(100 + i * 10);
      endcase
      send_request(CMD_CREATE, i[3:0], tv,
                   (i == 0) ? 63'd0 : (i == 1 || i == 4) ? T_NEVER :
                   (i == 5) ? 63'h2AAA_AAAA_AAAA_AAAA : 63'(50 + i), 0);
    end
    send_request(CMD_REGISTER, 4'd0, '0, '0, 0);
    send_request(CMD_REGISTER, 4'd1, '0, '0, 1);
    send_request(CMD_REGISTER, 4'd4, '0, '0, 0);
    send_request(CMD_REGISTER, 4'd4, '0, '0, 0);
    send_request(CMD_RENEW, 4'd4, '0, '0, 0);
    send_request(CMD_SET_EXPIRY, 4'd5, 63'd30, '0, 2);
    send_request(CMD_SET_EXPIRY, 4'd6, T_NEVER, '0, 0);
    send_request(CMD_REGISTER, 4'd15, '0, '0, 0);
    send_request(CMD_UNREGISTER, 4'd15, '0, '0, 0);
    send_request(CMD_CHECK, 4'd15, '0, '0, 0);
    send_request(CMD_CHECK, 4'd0, 63'd120, T_NEVER, 0);
    send_request(CMD_BAD_LO, 4'd3, T_NEVER, T_NEVER, 0);
    send_request(CMD_BAD_HI, 4'd2, '0, '0, 0);
    send_request(CMD_CHECK, 4'd0, T_NEVER, '0, 3);

    now_t = 63'd1000;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == RANDOM_REQUESTS / 2) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 12) cmd = CMD_CREATE;
      else if (r < 35) cmd = CMD_REGISTER;
      else if (r < 42) cmd = CMD_UNREGISTER;
      else if (r < 57) cmd = CMD_RENEW;
      else if (r < 72) cmd = CMD_SET_EXPIRY;
      else if (r < 97) cmd = CMD_CHECK;
      else cmd = $urandom_range(0, 1) ? CMD_BAD_LO : CMD_BAD_HI;
      if (cmd == CMD_CHECK) begin
        now_t = now_t + 63'($urandom_range(0, 150));
        tv = ($urandom_range(0, 19) == 0) ? rand_wide() : now_t;
      end else if (cmd == CMD_RENEW) begin
        tv = ($urandom_range(0, 9) == 0) ? rand_wide() : now_t;
      end else begin
        tv = pick_time();
      end
      send_request(cmd, 4'($urandom_range(0, 15)), tv, pick_duration(),
                   ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17));
    end
    @(negedge clk);
    start <= 1'b0;
    wait_drained();
    repeat (40) @(posedge clk);

    $display("ran %0d requests, checked %0d results including %0d expired leases",
             requests, sb.checked, sb.expirations);
    if (sb.errors == 0 && sb.expected_results.size() == 0)
      $display("lease_expiry_tracker_core: match");
    else
      $display("lease_expiry_tracker_core: mismatch");
    $finish;
  end
endmodule
